// ----- hdl/bqs_pkg.sv -----
// Package: shared types, codes and reset constants of the beep queue sequencer
`timescale 1ns / 1ps
`default_nettype none

package bqs_pkg;

  // Deadline arithmetic width, default
  localparam int unsigned TIME_WIDTH_DEFAULT = 32;

  // Event codes carried in the mode field
  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_QUEUE  = 2'd1;
  localparam logic [1:0] MODE_CANCEL = 2'd2;
  localparam logic [1:0] MODE_ALARM  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_PULSE_ON  = 2'd0;
  localparam logic [1:0] REG_PULSE_GAP = 2'd1;
  localparam logic [1:0] REG_Q_LIMIT   = 2'd2;

  // Configuration reset values
  localparam logic [15:0] PULSE_ON_RESET  = 16'd100;
  localparam logic [15:0] PULSE_GAP_RESET = 16'd50;
  localparam logic [3:0]  Q_LIMIT_RESET   = 4'd8;

  // Input transaction
  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] now_time;
    logic        alarm_enable;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic        buzzer_on;
    logic [3:0]  pending_beeps;
    logic [31:0] beeps_started;
    logic        alarm_active;
  } out_item_t;

  // Control flags of the sequencer
  typedef struct packed {
    logic alarm;
    logic level;
    logic pulse;
    logic gap;
  } seq_flags_t;

endpackage : bqs_pkg

`default_nettype wire

// ----- hdl/bqs_step.sv -----
// Next-state logic of the beep queue sequencer for one event
`timescale 1ns / 1ps
`default_nettype none

module bqs_step
  import bqs_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEFAULT,
  localparam int unsigned DW = (TIME_WIDTH < 32) ? TIME_WIDTH : 32
) (
  input  in_item_t         item,
  input  logic [15:0]      pulse_on_time,
  input  logic [15:0]      pulse_gap_time,
  input  logic [3:0]       queue_limit,
  input  seq_flags_t       flags,
  input  logic [3:0]       queued,
  input  logic [DW-1:0]    deadline,
  input  logic [31:0]      started,
  output seq_flags_t       flags_next,
  output logic [3:0]       queued_next,
  output logic [DW-1:0]    deadline_next,
  output logic [31:0]      started_next
);

  logic [DW-1:0]         now_t;
  logic [TIME_WIDTH-1:0] diff;
  logic                  reached;
  logic                  have_beeps;

  // Wrap-safe deadline test: signed difference of now and deadline is not negative
  assign now_t      = item.now_time[DW-1:0];
  assign diff       = TIME_WIDTH'(now_t) - TIME_WIDTH'(deadline);
  assign reached    = ~diff[TIME_WIDTH-1];
  assign have_beeps = (queued != 4'd0);

  // Apply the event
  always_comb begin
    flags_next    = flags;
    queued_next   = queued;
    deadline_next = deadline;
    started_next  = started;
    unique case (item.mode)
      MODE_TICK: begin
        if (flags.alarm) begin
          flags_next.level = 1'b1;
        end else if (flags.pulse) begin
          // End the pulse; open a gap only if more beeps wait
          if (reached) begin
            flags_next.level = 1'b0;
            flags_next.pulse = 1'b0;
            flags_next.gap   = have_beeps;
            deadline_next    = now_t + DW'(pulse_gap_time);
          end
        end else if (!flags.gap || reached) begin
          flags_next.gap = 1'b0;
          // Start the next beep on this same tick
          if (have_beeps) begin
            queued_next      = queued - 4'd1;
            started_next     = started + 32'd1;
            flags_next.level = 1'b1;
            flags_next.pulse = 1'b1;
            deadline_next    = now_t + DW'(pulse_on_time);
          end
        end
      end
      MODE_QUEUE: begin
        if (!flags.alarm && (queued < queue_limit)) begin
          queued_next = queued + 4'd1;
        end
      end
      MODE_CANCEL: begin
        queued_next      = 4'd0;
        flags_next.pulse = 1'b0;
        flags_next.gap   = 1'b0;
        if (!flags.alarm) begin
          flags_next.level = 1'b0;
        end
      end
      MODE_ALARM: begin
        queued_next      = 4'd0;
        flags_next.pulse = 1'b0;
        flags_next.gap   = 1'b0;
        flags_next.alarm = item.alarm_enable;
        flags_next.level = item.alarm_enable;
      end
      default: begin
        flags_next = flags;
      end
    endcase
  end

endmodule : bqs_step

`default_nettype wire

// ----- hdl/beep_queue_sequencer.sv -----
// Top level: beep queue sequencer with configuration registers and result register
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_ready  | in_data  (in_item_t)
// out     | output    | out_valid/out_ready| out_data (out_item_t)
// cfg     | input     | cfg_write          | cfg_index, cfg_data
//
// One event per clock while out_ready is high: an accepted event loads the state
// registers and the result register at the same clock edge.
// in_ready is high while the result register is empty or being drained, so an
// event is taken in the cycle its predecessor's result leaves.
// Synchronous reset clears the state, empties the result register and loads
// the configuration defaults.

module beep_queue_sequencer
  import bqs_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEFAULT,
  localparam int unsigned DW = (TIME_WIDTH < 32) ? TIME_WIDTH : 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [15:0]   pulse_on_time;
  logic [15:0]   pulse_gap_time;
  logic [3:0]    queue_limit;
  seq_flags_t    flags;
  seq_flags_t    flags_next;
  logic [3:0]    queued;
  logic [3:0]    queued_next;
  logic [DW-1:0] deadline;
  logic [DW-1:0] deadline_next;
  logic [31:0]   started;
  logic [31:0]   started_next;
  logic          accept;

  assign in_ready = ~out_valid | out_ready;
  assign accept   = in_valid & in_ready;

  // Configuration registers; unknown index is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_on_time  <= PULSE_ON_RESET;
      pulse_gap_time <= PULSE_GAP_RESET;
      queue_limit    <= Q_LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PULSE_ON:  pulse_on_time  <= cfg_data;
        REG_PULSE_GAP: pulse_gap_time <= cfg_data;
        REG_Q_LIMIT:   queue_limit    <= cfg_data[3:0];
        default:       ;
      endcase
    end
  end

  bqs_step #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_step (
    .item           (in_data),
    .pulse_on_time  (pulse_on_time),
    .pulse_gap_time (pulse_gap_time),
    .queue_limit    (queue_limit),
    .flags          (flags),
    .queued         (queued),
    .deadline       (deadline),
    .started        (started),
    .flags_next     (flags_next),
    .queued_next    (queued_next),
    .deadline_next  (deadline_next),
    .started_next   (started_next)
  );

  // Advance the sequencer state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      flags    <= '0;
      queued   <= '0;
      deadline <= '0;
      started  <= '0;
    end else if (accept) begin
      flags    <= flags_next;
      queued   <= queued_next;
      deadline <= deadline_next;
      started  <= started_next;
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.buzzer_on     <= flags_next.level;
      out_data.pending_beeps <= queued_next;
      out_data.beeps_started <= started_next;
      out_data.alarm_active  <= flags_next.alarm;
    end
  end

endmodule : beep_queue_sequencer

`default_nettype wire
